// ===== sv/fcfp_pkg.sv =====
// ----------------------------------------------------------------------------
// fcfp_pkg: shared types and constants of the framed command field parser
// Character codes, field kinds, value widths and the result record.
// ----------------------------------------------------------------------------
package fcfp_pkg;

    localparam int unsigned FRAME_LIMIT = 40;
    localparam int unsigned FIELD_CHARS = 9;

    localparam int unsigned ACC_W = 30;
    localparam int unsigned CUR_W = 32;
    localparam int unsigned LEN_W = 6;
    localparam int unsigned CHR_W = 4;
    localparam int unsigned FRC_W = 3;

    localparam logic [7:0] CH_S   = 8'h53;
    localparam logic [7:0] CH_E   = 8'h45;
    localparam logic [7:0] CH_C   = 8'h63;
    localparam logic [7:0] CH_D   = 8'h64;
    localparam logic [7:0] CH_F   = 8'h66;
    localparam logic [7:0] CH_1   = 8'h31;
    localparam logic [7:0] CH_2   = 8'h32;
    localparam logic [7:0] CH_0   = 8'h30;
    localparam logic [7:0] CH_9   = 8'h39;
    localparam logic [7:0] CH_DOT = 8'h2E;

    localparam logic [1:0] FLD_NONE = 2'd0;
    localparam logic [1:0] FLD_CUR  = 2'd1;
    localparam logic [1:0] FLD_DUTY = 2'd2;
    localparam logic [1:0] FLD_FREQ = 2'd3;

    localparam logic [FRC_W-1:0] FRAC_NONE  = 3'd0;
    localparam logic [FRC_W-1:0] FRAC_POINT = 3'd1;
    localparam logic [FRC_W-1:0] FRAC_TWO   = 3'd2;
    localparam logic [FRC_W-1:0] FRAC_ONE   = 3'd3;
    localparam logic [FRC_W-1:0] FRAC_FULL  = 3'd4;

    typedef logic [ACC_W-1:0] t_acc;
    typedef logic [CUR_W-1:0] t_cur;

    typedef struct packed {
        logic [CHR_W-1:0] chars;
        logic             stopped;
        logic [FRC_W-1:0] frac;
        t_acc             acc;
    } t_field_state;

    typedef struct packed {
        logic led_on;
        logic end_seen;
        logic frame_ok;
        t_cur current_milli;
        t_acc duty_value;
        t_acc frequency_value;
    } t_result;

    function automatic logic [1:0] mark_kind(input logic [7:0] b);
        logic [1:0] k;
        begin
            k = FLD_NONE;
            if (b == CH_C) k = FLD_CUR;
            if (b == CH_D) k = FLD_DUTY;
            if (b == CH_F) k = FLD_FREQ;
            return k;
        end
    endfunction

endpackage

// ===== sv/fcfp_in_if.sv =====
// ----------------------------------------------------------------------------
// fcfp_in_if: received byte channel
// Valid/ready channel that carries one received character per request.
// ----------------------------------------------------------------------------
interface fcfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== sv/fcfp_out_if.sv =====
// ----------------------------------------------------------------------------
// fcfp_out_if: parser result channel
// Valid/ready channel that carries the LED level, frame flags and held fields.
// ----------------------------------------------------------------------------
interface fcfp_out_if;
    logic        valid;
    logic        ready;
    logic        led_on;
    logic        end_seen;
    logic        frame_ok;
    logic [31:0] current_milli;
    logic [29:0] duty_value;
    logic [29:0] frequency_value;

    modport source (output valid, output led_on, output end_seen, output frame_ok,
                    output current_milli, output duty_value, output frequency_value,
                    input ready);
    modport sink (input valid, input led_on, input end_seen, input frame_ok,
                  input current_milli, input duty_value, input frequency_value,
                  output ready);
endinterface

// ===== sv/framed_command_field_parser.sv =====
// ----------------------------------------------------------------------------
// framed_command_field_parser: command stream frame and field parser
// Byte-wide command parser with an input register and a result register.
// ----------------------------------------------------------------------------
// Usage:
// Received characters enter on i_rx, one per request, under valid/ready.
// Every character gives exactly one result request on o_res, in order.
// 'S' opens a frame, 'c', 'd' and 'f' pairs enclose decimal fields, and
// 'E' closes the frame and updates the held current, duty and frequency.
// Bytes '1' and '2' switch the LED level off and on.
// A character passes an input register and then the result register before
// its result is shown. One character is accepted in every cycle while o_res
// is taken; the frame and field state is updated combinationally from each
// character and registered, which allows that rate.
// Reset clears the frame state, the held values and the LED level and empties
// both registers. When the receiver stalls, the result is held; one more
// character is taken into an empty input register before i_rx.ready drops.
// ----------------------------------------------------------------------------
module framed_command_field_parser
    import fcfp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    fcfp_in_if.sink    i_rx,
    fcfp_out_if.source o_res
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    logic       advance;
    logic       step;
    t_result    res;

    assign advance    = !r_out_valid || o_res.ready;
    assign step       = r_in_valid && advance;
    assign i_rx.ready = i_rst_n && (!r_in_valid || advance);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_rx.valid && i_rx.ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    fcfp_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .o_res   (res)
    );

    assign o_res.valid           = r_out_valid;
    assign o_res.led_on          = res.led_on;
    assign o_res.end_seen        = res.end_seen;
    assign o_res.frame_ok        = res.frame_ok;
    assign o_res.current_milli   = res.current_milli;
    assign o_res.duty_value      = res.duty_value;
    assign o_res.frequency_value = res.frequency_value;

endmodule

// ===== sv/fcfp_text_acc.sv =====
// ----------------------------------------------------------------------------
// fcfp_text_acc: field text accumulator
// Takes one text character into the open field's decimal value.
// ----------------------------------------------------------------------------
module fcfp_text_acc
    import fcfp_pkg::*;
(
    input  t_field_state i_state,
    input  logic [7:0]   i_byte,
    input  logic         i_is_current,
    output t_field_state o_state
);

    logic       is_digit;
    logic [3:0] digit;
    logic [ACC_W+3:0] mac;

    assign is_digit = (i_byte >= CH_0) && (i_byte <= CH_9);
    assign digit    = 4'(i_byte - CH_0);
    assign mac      = (ACC_W+4)'(i_state.acc) * (ACC_W+4)'(10) + (ACC_W+4)'(digit);

    always_comb begin
        o_state = i_state;
        if (i_state.chars < CHR_W'(FIELD_CHARS)) begin
            o_state.chars = i_state.chars + CHR_W'(1);
            if (!i_state.stopped) begin
                if (is_digit) begin
                    if (i_state.frac == FRAC_NONE) begin
                        o_state.acc = mac[ACC_W-1:0];
                    end else if (i_state.frac < FRAC_FULL) begin
                        o_state.acc  = mac[ACC_W-1:0];
                        o_state.frac = i_state.frac + FRC_W'(1);
                    end
                end else if (i_byte == CH_DOT && i_is_current
                             && i_state.frac == FRAC_NONE) begin
                    o_state.frac = FRAC_POINT;
                end else begin
                    o_state.stopped = 1'b1;
                end
            end
        end
    end

endmodule

// ===== sv/fcfp_cur_scale.sv =====
// ----------------------------------------------------------------------------
// fcfp_cur_scale: current field scaling
// Scales the digit value to thousandths and saturates it to 32 bits.
// ----------------------------------------------------------------------------
module fcfp_cur_scale
    import fcfp_pkg::*;
(
    input  t_acc             i_acc,
    input  logic [FRC_W-1:0] i_frac,
    output t_cur             o_current
);

    localparam int unsigned PROD_W = ACC_W + 10;

    logic [9:0]        scale;
    logic [PROD_W-1:0] prod;

    always_comb begin
        case (i_frac)
            FRAC_NONE, FRAC_POINT: scale = 10'd1000;
            FRAC_TWO:              scale = 10'd100;
            FRAC_ONE:              scale = 10'd10;
            default:               scale = 10'd1;
        endcase
    end

    assign prod      = PROD_W'(i_acc) * PROD_W'(scale);
    assign o_current = (|prod[PROD_W-1:CUR_W]) ? '1 : prod[CUR_W-1:0];

endmodule

// ===== sv/fcfp_parser.sv =====
// ----------------------------------------------------------------------------
// fcfp_parser: frame and field state with result register
// Updates framing, field and held values for one byte and registers the result.
// ----------------------------------------------------------------------------
module fcfp_parser
    import fcfp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    output t_result    o_res
);

    logic             r_in_frame,  n_in_frame;
    logic [LEN_W-1:0] r_len,       n_len;
    logic [1:0]       r_open,      n_open;
    logic [2:0]       r_done,      n_done;
    t_field_state     r_fld,       n_fld;
    t_cur             r_pend_cur,  n_pend_cur;
    t_acc             r_pend_duty, n_pend_duty;
    t_acc             r_pend_freq, n_pend_freq;
    t_cur             r_held_cur,  n_held_cur;
    t_acc             r_held_duty, n_held_duty;
    t_acc             r_held_freq, n_held_freq;
    logic             r_led,       n_led;
    t_result          r_res,       n_res;

    t_field_state fld_text;
    t_cur         cur_scaled;
    logic [1:0]   kind;
    logic         kind_done;
    logic         end_seen;
    logic         frame_ok;
    logic         live;

    fcfp_text_acc u_text (
        .i_state      (r_fld),
        .i_byte       (i_byte),
        .i_is_current (r_open == FLD_CUR),
        .o_state      (fld_text)
    );

    fcfp_cur_scale u_scale (
        .i_acc     (r_fld.acc),
        .i_frac    (r_fld.frac),
        .o_current (cur_scaled)
    );

    assign kind = mark_kind(i_byte);

    always_comb begin
        case (kind)
            FLD_CUR:  kind_done = r_done[0];
            FLD_DUTY: kind_done = r_done[1];
            FLD_FREQ: kind_done = r_done[2];
            default:  kind_done = 1'b1;
        endcase
    end

    always_comb begin
        n_in_frame  = r_in_frame;
        n_len       = r_len;
        n_open      = r_open;
        n_done      = r_done;
        n_fld       = r_fld;
        n_pend_cur  = r_pend_cur;
        n_pend_duty = r_pend_duty;
        n_pend_freq = r_pend_freq;
        n_held_cur  = r_held_cur;
        n_held_duty = r_held_duty;
        n_held_freq = r_held_freq;
        n_led       = r_led;
        end_seen    = 1'b0;
        frame_ok    = 1'b0;
        live        = 1'b0;

        if (i_byte == CH_1) n_led = 1'b0;
        if (i_byte == CH_2) n_led = 1'b1;

        if (i_byte == CH_S) begin
            n_in_frame  = 1'b1;
            n_len       = LEN_W'(1);
            n_open      = FLD_NONE;
            n_done      = 3'b000;
            n_pend_cur  = '0;
            n_pend_duty = '0;
            n_pend_freq = '0;
        end else begin
            live = r_in_frame;
            if (r_in_frame && r_len >= LEN_W'(FRAME_LIMIT)) begin
                live       = 1'b0;
                n_in_frame = 1'b0;
                n_open     = FLD_NONE;
            end
            end_seen = (i_byte == CH_E);
            if (live) begin
                n_len = r_len + LEN_W'(1);
                if (i_byte == CH_E) begin
                    if (r_done[0]) n_held_cur  = r_pend_cur;
                    if (r_done[1]) n_held_duty = r_pend_duty;
                    if (r_done[2]) n_held_freq = r_pend_freq;
                    frame_ok   = 1'b1;
                    n_in_frame = 1'b0;
                    n_open     = FLD_NONE;
                end else if (r_open != FLD_NONE) begin
                    if (kind == r_open) begin
                        case (r_open)
                            FLD_CUR: begin
                                n_pend_cur = cur_scaled;
                                n_done[0]  = 1'b1;
                            end
                            FLD_DUTY: begin
                                n_pend_duty = r_fld.acc;
                                n_done[1]   = 1'b1;
                            end
                            default: begin
                                n_pend_freq = r_fld.acc;
                                n_done[2]   = 1'b1;
                            end
                        endcase
                        n_open = FLD_NONE;
                    end else begin
                        n_fld = fld_text;
                    end
                end else if (!kind_done) begin
                    n_open        = kind;
                    n_fld.chars   = '0;
                    n_fld.stopped = 1'b0;
                    n_fld.frac    = FRAC_NONE;
                    n_fld.acc     = '0;
                end
            end
        end

        n_res.led_on          = n_led;
        n_res.end_seen        = end_seen;
        n_res.frame_ok        = frame_ok;
        n_res.current_milli   = n_held_cur;
        n_res.duty_value      = n_held_duty;
        n_res.frequency_value = n_held_freq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame  <= 1'b0;
            r_len       <= '0;
            r_open      <= FLD_NONE;
            r_done      <= '0;
            r_fld       <= '0;
            r_pend_cur  <= '0;
            r_pend_duty <= '0;
            r_pend_freq <= '0;
            r_held_cur  <= '0;
            r_held_duty <= '0;
            r_held_freq <= '0;
            r_led       <= 1'b0;
        end else if (i_step) begin
            r_in_frame  <= n_in_frame;
            r_len       <= n_len;
            r_open      <= n_open;
            r_done      <= n_done;
            r_fld       <= n_fld;
            r_pend_cur  <= n_pend_cur;
            r_pend_duty <= n_pend_duty;
            r_pend_freq <= n_pend_freq;
            r_held_cur  <= n_held_cur;
            r_held_duty <= n_held_duty;
            r_held_freq <= n_held_freq;
            r_led       <= n_led;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

// ===== bench/framed_command_field_parser_tb.sv =====
// ----------------------------------------------------------------------------
// framed_command_field_parser_tb: self-checking bench for the command parser
// Sends directed and random command streams through the received byte
// channel. Both sides idle and stall at random. A local predictor of the
// frame and field state computes each result. Every result request is
// compared in order against that prediction.
// ----------------------------------------------------------------------------
module framed_command_field_parser_tb;
    import fcfp_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int REPORT_MAX = 10;

    logic clk;
    logic rst_n;

    fcfp_in_if  rx_if();
    fcfp_out_if res_if();

    framed_command_field_parser u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_rx    (rx_if),
        .o_res   (res_if)
    );

    // Predicted parser state.
    logic             frame_open;
    logic [LEN_W-1:0] frame_bytes;
    logic [1:0]       field_kind;
    logic [2:0]       fields_complete;
    logic [CHR_W-1:0] text_count;
    logic             number_ended;
    logic [FRC_W-1:0] point_state;
    logic [63:0]      digit_value;
    t_cur             next_current;
    t_acc             next_duty;
    t_acc             next_freq;
    t_cur             latched_current;
    t_acc             latched_duty;
    t_acc             latched_freq;
    logic             led_level;

    t_result expected_status_q[$];
    int      fail_count;
    int      result_count;
    int      sent_count;
    int      hold_request;
    bit      steady_flow;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void clear_parser_state();
        frame_open      = 1'b0;
        frame_bytes     = '0;
        field_kind      = FLD_NONE;
        fields_complete = '0;
        text_count      = '0;
        number_ended    = 1'b0;
        point_state     = FRAC_NONE;
        digit_value     = '0;
        next_current    = '0;
        next_duty       = '0;
        next_freq       = '0;
        latched_current = '0;
        latched_duty    = '0;
        latched_freq    = '0;
        led_level       = 1'b0;
    endfunction

    function automatic logic [1:0] field_of_mark(input logic [7:0] b);
        case (b)
            CH_C: return FLD_CUR;
            CH_D: return FLD_DUTY;
            CH_F: return FLD_FREQ;
            default: return FLD_NONE;
        endcase
    endfunction

    function automatic void start_field(input logic [1:0] kind);
        field_kind   = kind;
        text_count   = '0;
        number_ended = 1'b0;
        point_state  = FRAC_NONE;
        digit_value  = '0;
    endfunction

    function automatic void take_char(input logic [7:0] b);
        if (text_count < CHR_W'(FIELD_CHARS)) begin
            text_count = text_count + CHR_W'(1);
            if (!number_ended) begin
                if (b >= CH_0 && b <= CH_9) begin
                    if (point_state == FRAC_NONE) begin
                        digit_value = digit_value * 64'd10 + 64'(b - CH_0);
                    end else if (point_state < FRAC_FULL) begin
                        digit_value = digit_value * 64'd10 + 64'(b - CH_0);
                        point_state = point_state + FRC_W'(1);
                    end
                end else if (b == CH_DOT && field_kind == FLD_CUR &&
                             point_state == FRAC_NONE) begin
                    point_state = FRAC_POINT;
                end else begin
                    number_ended = 1'b1;
                end
            end
        end
    endfunction

    function automatic void close_field();
        logic [63:0] scaled;
        int          frac_digits;
        if (field_kind == FLD_CUR) begin
            scaled = digit_value;
            frac_digits = (point_state > FRAC_NONE) ? int'(point_state) - 1 : 0;
            while (frac_digits < 3) begin
                scaled = scaled * 64'd10;
                frac_digits++;
            end
            next_current = (scaled > 64'h0000_0000_FFFF_FFFF) ? '1 : scaled[CUR_W-1:0];
            fields_complete[0] = 1'b1;
        end else if (field_kind == FLD_DUTY) begin
            next_duty = digit_value[ACC_W-1:0];
            fields_complete[1] = 1'b1;
        end else if (field_kind == FLD_FREQ) begin
            next_freq = digit_value[ACC_W-1:0];
            fields_complete[2] = 1'b1;
        end
        field_kind = FLD_NONE;
    endfunction

    function automatic t_result parse_byte(input logic [7:0] b);
        t_result    res;
        logic [1:0] kind;
        res = '0;
        if (b == CH_1) led_level = 1'b0;
        if (b == CH_2) led_level = 1'b1;
        if (b == CH_S) begin
            frame_open      = 1'b1;
            frame_bytes     = LEN_W'(1);
            field_kind      = FLD_NONE;
            fields_complete = '0;
            next_current    = '0;
            next_duty       = '0;
            next_freq       = '0;
        end else begin
            if (frame_open && frame_bytes >= LEN_W'(FRAME_LIMIT)) begin
                frame_open = 1'b0;
                field_kind = FLD_NONE;
            end
            res.end_seen = (b == CH_E);
            if (frame_open) begin
                frame_bytes = frame_bytes + LEN_W'(1);
                if (b == CH_E) begin
                    if (fields_complete[0]) latched_current = next_current;
                    if (fields_complete[1]) latched_duty = next_duty;
                    if (fields_complete[2]) latched_freq = next_freq;
                    res.frame_ok = 1'b1;
                    frame_open = 1'b0;
                    field_kind = FLD_NONE;
                end else if (field_kind != FLD_NONE) begin
                    if (field_of_mark(b) == field_kind) close_field();
                    else take_char(b);
                end else begin
                    kind = field_of_mark(b);
                    if (kind != FLD_NONE && !fields_complete[int'(kind) - 1]) begin
                        start_field(kind);
                    end
                end
            end
        end
        res.led_on          = led_level;
        res.current_milli   = latched_current;
        res.duty_value      = latched_duty;
        res.frequency_value = latched_freq;
        return res;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady_flow || roll < 65) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do @(posedge clk); while (!rx_if.ready);
        expected_status_q.push_back(parse_byte(b));
        sent_count++;
    endtask

    task automatic pause_until_drained();
        rx_if.valid <= 1'b0;
        do @(posedge clk); while (expected_status_q.size() != 0);
    endtask

    function automatic logic [7:0] digit_byte(input bit all_nines);
        if (all_nines || $urandom_range(0, 7) == 0) return CH_9;
        return CH_0 + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] filler_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == CH_S || b == CH_E);
        return b;
    endfunction

    // A frame with random fields; some are broken: a field left open, a
    // stray byte, a missing end mark, or padding past the length limit.
    task automatic send_random_frame();
        logic [7:0] burst[$];
        logic [7:0] marks[3];
        logic [7:0] tmp;
        int         n_fields;
        int         len;
        int         point_at;
        int         target;
        int         roll;
        bit         nines;
        marks[0] = CH_C;
        marks[1] = CH_D;
        marks[2] = CH_F;
        for (int i = 2; i > 0; i--) begin
            int j;
            j = $urandom_range(0, i);
            tmp = marks[i];
            marks[i] = marks[j];
            marks[j] = tmp;
        end
        burst.push_back(CH_S);
        n_fields = $urandom_range(0, 3);
        for (int i = 0; i < n_fields; i++) begin
            if ($urandom_range(0, 9) == 0) burst.push_back(8'($urandom_range(0, 255)));
            burst.push_back(marks[i]);
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 12) : $urandom_range(0, 9);
            nines = ($urandom_range(0, 9) == 0);
            point_at = (marks[i] == CH_C && $urandom_range(0, 1) == 1) ?
                       $urandom_range(0, len) : -1;
            for (int j = 0; j < len; j++) begin
                if (j == point_at) burst.push_back(CH_DOT);
                else if (!nines && $urandom_range(0, 19) == 0) burst.push_back(filler_byte());
                else burst.push_back(digit_byte(nines));
            end
            if ($urandom_range(0, 11) != 0) burst.push_back(marks[i]);
        end
        roll = $urandom_range(0, 9);
        if (roll == 0) begin
            target = $urandom_range(38, 44);
            while (burst.size() < target) burst.push_back(filler_byte());
        end
        if (roll != 1) burst.push_back(CH_E);
        foreach (burst[i]) send_byte(burst[i]);
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 5);
        repeat (n) send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic test_directed();
        logic [7:0] script[$];
        // End outside a frame, byte extremes, LED on, a current field with a
        // fraction, a repeated mark, a mark inside another field, a field
        // open at the end, then a restart inside a frame and LED off.
        script = '{CH_E, 8'h00, 8'hFF, CH_2,
                   CH_S, CH_C, CH_1, CH_DOT, "5", CH_C, CH_C,
                   CH_D, CH_F, CH_D, CH_F, CH_9, CH_E,
                   CH_S, CH_S, CH_F, CH_1, CH_F, CH_E};
        foreach (script[i]) send_byte(script[i]);
    endtask

    task automatic test_random_frames();
        int target;
        target = sent_count + 280;
        while (sent_count < target) begin
            if ($urandom_range(0, 4) == 0) send_noise();
            else send_random_frame();
        end
    endtask

    // The receiver holds off while requests keep coming, so the block fills
    // and drops its input ready.
    task automatic test_output_hold_off();
        steady_flow = 1'b1;
        hold_request = 150;
        rx_if.valid <= 1'b0;
        @(posedge clk);
        repeat (3) send_random_frame();
        steady_flow = 1'b0;
    endtask

    task automatic test_sender_pause();
        repeat (3) begin
            send_random_frame();
            pause_until_drained();
        end
    endtask

    task automatic test_steady_flow();
        int target;
        steady_flow = 1'b1;
        target = sent_count + 80;
        while (sent_count < target) send_random_frame();
        steady_flow = 1'b0;
    endtask

    task automatic check_result();
        t_result got;
        t_result want;
        got.led_on          = res_if.led_on;
        got.end_seen        = res_if.end_seen;
        got.frame_ok        = res_if.frame_ok;
        got.current_milli   = res_if.current_milli;
        got.duty_value      = res_if.duty_value;
        got.frequency_value = res_if.frequency_value;
        if (expected_status_q.size() == 0) begin
            if (fail_count < REPORT_MAX) begin
                $display("result %0d arrived with no request pending", result_count);
            end
            fail_count++;
        end else begin
            want = expected_status_q.pop_front();
            if (got.led_on !== want.led_on || got.end_seen !== want.end_seen ||
                got.frame_ok !== want.frame_ok ||
                got.current_milli !== want.current_milli ||
                got.duty_value !== want.duty_value ||
                got.frequency_value !== want.frequency_value) begin
                if (fail_count < REPORT_MAX) begin
                    $display({"mismatch on result %0d: expected led=%0b end=%0b ok=%0b",
                              " cur=%0d duty=%0d freq=%0d"},
                             result_count, want.led_on, want.end_seen, want.frame_ok,
                             want.current_milli, want.duty_value, want.frequency_value);
                    $display("    got led=%0b end=%0b ok=%0b cur=%0d duty=%0d freq=%0d",
                             got.led_on, got.end_seen, got.frame_ok, got.current_milli,
                             got.duty_value, got.frequency_value);
                end
                fail_count++;
            end
        end
        result_count++;
    endtask

    initial begin
        int hold_left;
        int roll;
        hold_left = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && res_if.valid && res_if.ready) check_result();
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left == 0 && !steady_flow) begin
                roll = $urandom_range(0, 99);
                if (roll >= 70) begin
                    if (roll < 92) hold_left = $urandom_range(1, 3);
                    else if (roll < 99) hold_left = $urandom_range(4, 12);
                    else hold_left = $urandom_range(30, 80);
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        forever begin
            @(posedge clk);
            if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("no request accepted for %0d cycles", IDLE_LIMIT);
                $display("[framed_command_field_parser] ERROR");
                $finish;
            end
        end
    end

    initial begin
        fail_count   = 0;
        result_count = 0;
        sent_count   = 0;
        hold_request = 0;
        steady_flow  = 1'b0;
        clear_parser_state();
        rst_n         <= 1'b0;
        rx_if.valid   <= 1'b0;
        rx_if.rx_byte <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_frames();
        test_output_hold_off();
        test_sender_pause();
        test_steady_flow();
        pause_until_drained();
        repeat (8) @(posedge clk);
        if (expected_status_q.size() != 0) begin
            $display("%0d expected results never arrived", expected_status_q.size());
            fail_count += expected_status_q.size();
        end
        if (fail_count == 0) begin
            $display("[framed_command_field_parser] OK");
        end else begin
            $display("[framed_command_field_parser] ERROR");
        end
        $finish;
    end

endmodule
